/* rtl/core/lpsd_pkg.sv */
`default_nettype none
package lpsd_pkg;

  localparam int unsigned HEADER_BYTES_DEF = 4;
  localparam int unsigned QUEUE_DEPTH_DEF  = 4;
  localparam logic [31:0] MAX_LEN_RESET    = 32'(343 * 1024);

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_DATA  = 2'd0;
  localparam kind_t KIND_RTT   = 2'd1;
  localparam kind_t KIND_ECHO  = 2'd2;
  localparam kind_t KIND_OVERSZ = 2'd3;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [31:0] len;
  } rec_t;

endpackage
`default_nettype wire

/* rtl/core/length_prefixed_stream_deframer_top.sv */
`default_nettype none
// Length-prefixed stream deframer. One received byte is taken per cycle
// while in_full is low; a big-endian length header of HEADER_BYTES bytes
// is gathered, a zero length yields an rtt reply marker, an all-ones
// length an echo request, a length above the configured maximum frame
// length an oversize error followed by silent skipping of that many bytes,
// and any other length passes its payload bytes out one per transaction
// with first/last marks. The parser handles one byte every cycle while
// in_full is low; its results go through a QUEUE_DEPTH-entry queue,
// visible on the out_ ports at the earliest from the cycle after the byte
// is taken. in_full rises only when the queue holds QUEUE_DEPTH results
// not yet popped. Write the maximum frame length only while idle.
module length_prefixed_stream_deframer_top
  import lpsd_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_stream_byte,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_payload_byte,
  output logic             out_first_of_frame,
  output logic             out_last_of_frame,
  output logic [31:0]      out_frame_length
);

  rec_t res;
  rec_t head;
  logic res_vld;
  logic q_full;

  assign in_full = q_full;

  lpsd_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_vld     (in_push && !q_full),
    .in_byte    (in_stream_byte),
    .res        (res),
    .res_vld    (res_vld)
  );

  lpsd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_vld),
    .wr_rec(res),
    .full  (q_full),
    .pop   (out_pop),
    .rd_rec(head),
    .empty (out_empty)
  );

  assign out_result_kind    = head.kind;
  assign out_payload_byte   = head.data;
  assign out_first_of_frame = head.first;
  assign out_last_of_frame  = head.last;
  assign out_frame_length   = head.len;

endmodule
`default_nettype wire

/* rtl/core/lpsd_front.sv */
`default_nettype none
module lpsd_front
  import lpsd_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_vld,
  input  wire logic [7:0]  in_byte,
  output rec_t             res,
  output logic             res_vld
);

  localparam int unsigned HDR_W = 8 * HEADER_BYTES;
  localparam int unsigned ACC_W = HDR_W - 8;
  localparam int unsigned CNT_W = $clog2(HEADER_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HEADER_BYTES - 1);
  localparam logic [31:0] ECHO_MASK =
    (HDR_W >= 32) ? 32'hffff_ffff : 32'((64'd1 << HDR_W) - 64'd1);

  localparam logic [1:0] ST_HUNT = 2'd0;
  localparam logic [1:0] ST_PASS = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [31:0]      cur_r, cur_nxt;
  logic [31:0]      max_r;
  logic [31:0]      hdr_len;

  assign hdr_len = 32'({acc_r, in_byte});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    cur_nxt   = cur_r;
    res_vld   = 1'b0;
    res       = '0;
    if (in_vld) begin
      unique case (state_r)
        ST_PASS: begin
          res_vld    = 1'b1;
          res.kind   = KIND_DATA;
          res.data   = in_byte;
          res.first  = (rem_r == cur_r);
          res.last   = (rem_r <= 32'd1);
          res.len    = cur_r;
          if (rem_r <= 32'd1) begin
            rem_nxt   = '0;
            state_nxt = ST_HUNT;
          end else begin
            rem_nxt = rem_r - 32'd1;
          end
        end
        ST_SKIP: begin
          if (rem_r <= 32'd1) begin
            rem_nxt   = '0;
            state_nxt = ST_HUNT;
          end else begin
            rem_nxt = rem_r - 32'd1;
          end
        end
        ST_HUNT: begin
          if (cnt_r == CNT_LAST) begin
            acc_nxt = '0;
            cnt_nxt = '0;
            if (hdr_len == 32'd0) begin
              res_vld  = 1'b1;
              res.kind = KIND_RTT;
            end else if (hdr_len == ECHO_MASK) begin
              res_vld  = 1'b1;
              res.kind = KIND_ECHO;
              res.len  = hdr_len;
            end else if (hdr_len > max_r) begin
              res_vld   = 1'b1;
              res.kind  = KIND_OVERSZ;
              res.len   = hdr_len;
              rem_nxt   = hdr_len;
              cur_nxt   = hdr_len;
              state_nxt = ST_SKIP;
            end else begin
              rem_nxt   = hdr_len;
              cur_nxt   = hdr_len;
              state_nxt = ST_PASS;
            end
          end else begin
            acc_nxt = ACC_W'({acc_r, in_byte});
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        default: begin
          state_nxt = ST_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      acc_r   <= '0;
      cnt_r   <= '0;
      rem_r   <= '0;
      cur_r   <= '0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      cur_r   <= cur_nxt;
    end
  end

`ifndef SYNTHESIS
  a_frame_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PASS || state_r == ST_SKIP) |-> rem_r != 32'd0)
    else $error("frame state with no bytes remaining");
  a_data_only_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld && state_r == ST_PASS) |-> (res_vld && res.kind == KIND_DATA))
    else $error("payload byte not forwarded");
  a_marks_on_data_only: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.kind != KIND_DATA) |-> (!res.first && !res.last && res.data == 8'd0))
    else $error("frame marks on a non-data transaction");
`endif

endmodule
`default_nettype wire

/* rtl/core/lpsd_queue.sv */
`default_nettype none
module lpsd_queue
  import lpsd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire rec_t wr_rec,
  output logic      full,
  input  wire logic pop,
  output rec_t      rd_rec,
  output logic      empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rec_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_rec  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("transaction pushed into a full queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && cnt_r != CNT_FULL) |-> wr_ptr_r != rd_ptr_r)
    else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire
